FILE: rtl/led_ring_flash_controller_unit_macros.svh
// Assertion macros for the LED ring flash controller.
`ifndef LED_RING_FLASH_CONTROLLER_UNIT_MACROS_SVH
`define LED_RING_FLASH_CONTROLLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LRFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrfc assertion failed");
`define LRFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrfc assertion failed");
`else
`define LRFC_ASSERT_IMPL(label, ante, cons)
`define LRFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/lrfc_pkg.sv
// Shared types and constants for the LED ring flash controller.
package lrfc_pkg;

  localparam int unsigned LRFC_CHANNELS = 16;

  localparam logic [7:0] COUNT_ENDLESS = 8'd255;
  localparam logic [3:0] DUR_HOLD      = 4'd15;
  localparam logic [4:0] SRC_NONE      = 5'd16;

  // configuration register indexes
  localparam logic [1:0] REG_INVERT_MASK  = 2'd0;
  localparam logic [1:0] REG_LAYERED_MODE = 2'd1;

  typedef enum logic [3:0] {
    OP_TICK          = 4'd0,
    OP_START         = 4'd1,
    OP_STOP          = 4'd2,
    OP_STOP_UNMASKED = 4'd3,
    OP_STOP_ALL      = 4'd4,
    OP_SET_SEGMENT   = 4'd5,
    OP_SELECT        = 4'd6,
    OP_FILL          = 4'd7,
    OP_MAP           = 4'd8,
    OP_UNMAP_ALL     = 4'd9
  } op_e;

  // one command word as held in the input register
  typedef struct packed {
    logic        fire;
    op_e         op;
    logic [3:0]  channel;
    logic [7:0]  flash_count;
    logic [3:0]  on_ticks;
    logic [3:0]  off_ticks;
    logic        start_on;
    logic [7:0]  tick_step;
    logic [3:0]  position;
    logic [4:0]  flash_source;
    logic [15:0] keep_mask;
    logic        segment_on;
  } cmd_t;

  // per-channel tick outcome
  typedef struct packed {
    logic upd;   // write the channel's phase (layered) or segment (direct) bit
    logic val;   // value to write
    logic fin;   // layered count reached zero
  } chan_evt_t;

endpackage

FILE: rtl/lrfc_chan.sv
// One flash channel: count, accumulator and durations with tick expiry logic.
module lrfc_chan import lrfc_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      layered_i,
  input  logic      phase_i,
  output chan_evt_t evt_o
);

  logic [7:0]  count_q, count_d;
  logic [15:0] acc_q, acc_d;
  logic [3:0]  on_q, on_d;
  logic [3:0]  off_q, off_d;

  logic        is_tick, active, expire, hit;
  logic [15:0] acc_sum;
  logic [3:0]  dur;

  assign hit     = cmd_i.channel == 4'(Idx);
  assign is_tick = cmd_i.fire && (cmd_i.op == OP_TICK);
  assign active  = count_q != 8'd0;
  assign acc_sum = acc_q + 16'(cmd_i.tick_step);
  assign dur     = phase_i ? on_q : off_q;
  assign expire  = is_tick && active && (acc_sum >= 16'(dur));

  always_comb begin
    count_d = count_q;
    acc_d   = acc_q;
    on_d    = on_q;
    off_d   = off_q;
    if (cmd_i.fire) begin
      case (cmd_i.op)
        OP_TICK: begin
          if (active) begin
            acc_d = expire ? acc_sum - 16'(dur) : acc_sum;
            if (expire && count_q != COUNT_ENDLESS) begin
              count_d = count_q - 8'd1;
            end
          end
        end
        OP_START: begin
          if (hit) begin
            count_d = cmd_i.flash_count;
            acc_d   = '0;
            on_d    = cmd_i.on_ticks;
            off_d   = cmd_i.off_ticks;
          end
        end
        OP_STOP: begin
          if (hit) count_d = '0;
        end
        OP_STOP_UNMASKED: begin
          if (!cmd_i.keep_mask[Idx]) count_d = '0;
        end
        OP_STOP_ALL: count_d = '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    evt_o.upd = expire && (layered_i || on_q != DUR_HOLD);
    if (layered_i) begin
      evt_o.val = phase_i ? (on_q == DUR_HOLD) : (off_q != DUR_HOLD);
    end else begin
      evt_o.val = !phase_i;
    end
    evt_o.fin = expire && layered_i && (count_q == 8'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      acc_q   <= '0;
      on_q    <= '0;
      off_q   <= '0;
    end else begin
      count_q <= count_d;
      acc_q   <= acc_d;
      on_q    <= on_d;
      off_q   <= off_d;
    end
  end

endmodule

FILE: rtl/lrfc_map.sv
// Segment-to-channel source map and the LED drive word built from it.
module lrfc_map import lrfc_pkg::*; #(
  parameter int unsigned CHANNELS = LRFC_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [15:0] fin_i,
  input  logic [15:0] seg_i,
  input  logic [15:0] phase_i,
  input  logic [15:0] invert_i,
  output logic [15:0] drive_o
);

  logic [4:0] map_q [CHANNELS];
  logic [4:0] map_d [CHANNELS];
  logic [4:0] src_val;

  assign src_val = (int'(cmd_i.flash_source) < CHANNELS) ? cmd_i.flash_source : SRC_NONE;

  always_comb begin
    for (int s = 0; s < CHANNELS; s++) begin
      map_d[s] = map_q[s];
      if (cmd_i.fire) begin
        case (cmd_i.op)
          OP_TICK: begin
            if (map_q[s] != SRC_NONE && fin_i[map_q[s][3:0]]) map_d[s] = SRC_NONE;
          end
          OP_MAP: begin
            if (int'(cmd_i.channel) == s) map_d[s] = src_val;
          end
          OP_UNMAP_ALL: map_d[s] = SRC_NONE;
          default: ;
        endcase
      end
    end
  end

  // drive word from the state after this command
  always_comb begin
    drive_o = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      drive_o[i] = invert_i[i] ^
                   ((map_d[i] == SRC_NONE) ? seg_i[i] : phase_i[map_d[i][3:0]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < CHANNELS; s++) map_q[s] <= SRC_NONE;
    end else begin
      for (int s = 0; s < CHANNELS; s++) map_q[s] <= map_d[s];
    end
  end

endmodule

FILE: rtl/led_ring_flash_controller_unit.sv
// LED ring flash controller: one result word per command.
// A command in the input register fires when the output word is not stuck,
// and its result word is then loaded into the output register.
// Throughput: a word per cycle unless stalled; all channels update in parallel.
// Reset (rst_ni low, async): segments, phases, counts, accumulators, durations,
// valid flags and config registers clear; every source map entry reads none.
`include "led_ring_flash_controller_unit_macros.svh"
module led_ring_flash_controller_unit import lrfc_pkg::*; #(
  parameter int unsigned CHANNELS = LRFC_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  opcode_i,
  input  logic [3:0]  channel_i,
  input  logic [7:0]  flash_count_i,
  input  logic [3:0]  on_ticks_i,
  input  logic [3:0]  off_ticks_i,
  input  logic        start_on_i,
  input  logic [7:0]  tick_step_i,
  input  logic [3:0]  position_i,
  input  logic [4:0]  flash_source_i,
  input  logic [15:0] keep_mask_i,
  input  logic        segment_on_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] led_drive_o,
  output logic [15:0] finished_mask_o,
  output logic [15:0] segment_word_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [15:0] ChanMask = 16'((17'd1 << CHANNELS) - 17'd1);

  // config registers
  logic [15:0] invert_q;
  logic        layered_q;

  // input register stage
  logic        in_valid_q;
  cmd_t        cmd_q;
  cmd_t        exec;
  logic        fire;

  // shared ring state
  logic [15:0] seg_q, seg_d;
  logic [15:0] phase_q, phase_d;
  logic [15:0] fin;
  logic [15:0] drive;

  // output register
  logic        out_valid_q;
  logic [15:0] drive_q, fin_q, segw_q;

  chan_evt_t   evt [CHANNELS];

  // the input register only holds when the output word is stuck
  assign in_stall_o  = in_valid_q && out_valid_q && out_stall_i;
  assign fire        = in_valid_q && !(out_valid_q && out_stall_i);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    exec      = cmd_q;
    exec.fire = fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= '0;
      layered_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_INVERT_MASK:  invert_q  <= cfg_data_i;
        REG_LAYERED_MODE: layered_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cmd_q.fire         <= 1'b0;
      cmd_q.op           <= op_e'(opcode_i);
      cmd_q.channel      <= channel_i;
      cmd_q.flash_count  <= flash_count_i;
      cmd_q.on_ticks     <= on_ticks_i;
      cmd_q.off_ticks    <= off_ticks_i;
      cmd_q.start_on     <= start_on_i;
      cmd_q.tick_step    <= tick_step_i;
      cmd_q.position     <= position_i;
      cmd_q.flash_source <= flash_source_i;
      cmd_q.keep_mask    <= keep_mask_i;
      cmd_q.segment_on   <= segment_on_i;
    end
  end

  // per-channel counters; phase seen is the segment bit in direct mode
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    lrfc_chan #(
      .Idx(c)
    ) u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (exec),
      .layered_i(layered_q),
      .phase_i  (layered_q ? phase_q[c] : seg_q[c]),
      .evt_o    (evt[c])
    );
  end

  always_comb begin
    fin = '0;
    for (int c = 0; c < CHANNELS; c++) fin[c] = evt[c].fin;
  end

  // segment and phase words
  always_comb begin
    seg_d   = seg_q;
    phase_d = phase_q;
    if (fire) begin
      case (cmd_q.op)
        OP_TICK: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (evt[c].upd) begin
              if (layered_q) phase_d[c] = evt[c].val;
              else           seg_d[c]   = evt[c].val;
            end
          end
        end
        OP_START: begin
          if (int'(cmd_q.channel) < CHANNELS) seg_d[cmd_q.channel] = cmd_q.start_on;
        end
        OP_STOP: begin
          if (int'(cmd_q.channel) < CHANNELS) seg_d[cmd_q.channel] = 1'b0;
        end
        OP_STOP_UNMASKED: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (!cmd_q.keep_mask[i]) seg_d[i] = 1'b0;
          end
        end
        OP_STOP_ALL:    seg_d = '0;
        OP_SET_SEGMENT: seg_d[cmd_q.channel] = cmd_q.segment_on;
        OP_SELECT:      seg_d = 16'd1 << cmd_q.position;
        OP_FILL: begin
          // all segments up to and including position
          for (int i = 0; i < 16; i++) seg_d[i] = (5'(i) <= {1'b0, cmd_q.position});
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= '0;
      phase_q <= '0;
    end else begin
      seg_q   <= seg_d;
      phase_q <= phase_d;
    end
  end

  lrfc_map #(
    .CHANNELS(CHANNELS)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (exec),
    .fin_i   (fin),
    .seg_i   (seg_d),
    .phase_i (phase_d),
    .invert_i(invert_q),
    .drive_o (drive)
  );

  // result register; drains when taken, refills on every fired command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      drive_q <= drive;
      fin_q   <= fin;
      segw_q  <= seg_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_drive_o     = drive_q;
  assign finished_mask_o = fin_q;
  assign segment_word_o  = segw_q;

  `LRFC_ASSERT_NEXT(a_fire_loads_out, fire, out_valid_q)
  `LRFC_ASSERT_IMPL(a_stall_only_when_full, in_stall_o, in_valid_q && out_valid_q)
  `LRFC_ASSERT_IMPL(a_no_bits_past_ring, out_valid_q,
                    ((drive_q | fin_q) & ~ChanMask) == 16'd0)
  `LRFC_ASSERT_IMPL(a_fin_only_layered, out_valid_q && fin_q != 16'd0, layered_q)

endmodule
